### hw/rtl/s2cd_pkg.sv
`timescale 1ns / 1ps

package s2cd_pkg;

    // Pipeline depth: stage 1 is the first register after the input port and
    // the last stage drives the output port.
    localparam int unsigned NUM_STG = 9;

    typedef logic [NUM_STG-1:0] t_stg_en;

    // Seconds to whole days. 86400 = 128 * 675, so the low seven bits pass
    // through and the rest is divided by 675 with an exact ceiling reciprocal.
    localparam int unsigned SEC_SHIFT   = 7;
    localparam int unsigned DAY_DIV_ODD = 675;
    localparam int unsigned DAY_K       = 35;
    localparam logic [25:0] RCP_DAY =
        26'(((64'd1 << DAY_K) + 64'(DAY_DIV_ODD) - 64'd1) / 64'(DAY_DIV_ODD));

    // Julian day of the epoch and the offset of the integer date algorithm.
    localparam int unsigned JDN_EPOCH  = 2440588;
    localparam int unsigned JDN_BIAS   = 32044;
    localparam logic [21:0] A_BASE     = 22'(JDN_EPOCH + JDN_BIAS);

    // 400-year cycles. A 32-bit seconds count only reaches centuries 67 to 69
    // of the shifted calendar, so two compares replace the division.
    localparam int unsigned DAYS_400Y = 146097;
    localparam int unsigned CEN_MIN   = 67;
    localparam logic [23:0] CEN_TH1   = 24'((CEN_MIN + 1) * DAYS_400Y);
    localparam logic [23:0] CEN_TH2   = 24'((CEN_MIN + 2) * DAYS_400Y);

    // Four-year cycles: (4a + 3) / 1461 for an 18-bit numerator.
    localparam int unsigned DAYS_4Y = 1461;
    localparam int unsigned YIC_K   = 29;
    localparam logic [18:0] RCP_YIC =
        19'(((64'd1 << YIC_K) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y));

    // Month index: (5a + 2) / 153 for an 11-bit numerator.
    localparam int unsigned MONTH_SPAN = 153;
    localparam int unsigned MI_K       = 19;
    localparam logic [11:0] RCP_MI =
        12'(((64'd1 << MI_K) + 64'(MONTH_SPAN) - 64'd1) / 64'(MONTH_SPAN));

    // Day within month: (153 * mi + 2) / 5 for an 11-bit numerator.
    localparam int unsigned DIV5   = 5;
    localparam int unsigned DIV5_K = 14;
    localparam logic [11:0] RCP_5 =
        12'(((64'd1 << DIV5_K) + 64'(DIV5) - 64'd1) / 64'(DIV5));

    localparam int unsigned YEAR_BIAS = 4800;

    // Time of day.
    localparam int unsigned SEC_HOUR = 3600;
    localparam int unsigned HOUR_K   = 29;
    localparam logic [17:0] RCP_HOUR =
        18'(((64'd1 << HOUR_K) + 64'(SEC_HOUR) - 64'd1) / 64'(SEC_HOUR));

    localparam int unsigned SEC_MIN = 60;
    localparam int unsigned MIN_K   = 18;
    localparam logic [12:0] RCP_MIN =
        13'(((64'd1 << MIN_K) + 64'(SEC_MIN) - 64'd1) / 64'(SEC_MIN));

    // Weekday: Julian day mod 7, Monday is zero.
    localparam int unsigned WEEK_DAYS = 7;
    localparam logic [2:0]  WD_OFS    = 3'(JDN_EPOCH % WEEK_DAYS);
    localparam int unsigned WD_K      = 20;
    localparam logic [17:0] RCP_WD =
        18'(((64'd1 << WD_K) + 64'(WEEK_DAYS) - 64'd1) / 64'(WEEK_DAYS));

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
    } t_date_out;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] weekday;
    } t_clock_out;

endpackage

### hw/rtl/s2cd_day_split.sv
`timescale 1ns / 1ps

// Stages 1 and 2: split the seconds count into whole days and seconds of day.
module s2cd_day_split (
    input  logic                i_clk,
    input  s2cd_pkg::t_stg_en   i_en,
    input  logic [31:0]         i_seconds_count,
    output logic [15:0]         o_days,
    output logic [16:0]         o_tod
);

    logic [24:0] r1_x;
    logic [6:0]  r1_lo;
    logic [50:0] r1_prod;
    logic [50:0] n1_prod;

    logic [15:0] n2_days;
    logic [25:0] n2_back;
    logic [9:0]  n2_rem;
    logic [15:0] r2_days;
    logic [16:0] r2_tod;

    always_comb begin
        n1_prod = 51'(i_seconds_count[31:s2cd_pkg::SEC_SHIFT]) * 51'(s2cd_pkg::RCP_DAY);
        n2_days = r1_prod[50:s2cd_pkg::DAY_K];
        n2_back = 26'(n2_days) * 26'(s2cd_pkg::DAY_DIV_ODD);
        n2_rem  = 10'(r1_x - n2_back[24:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_x    <= i_seconds_count[31:s2cd_pkg::SEC_SHIFT];
            r1_lo   <= i_seconds_count[s2cd_pkg::SEC_SHIFT-1:0];
            r1_prod <= n1_prod;
        end
        if (i_en[1]) begin
            r2_days <= n2_days;
            r2_tod  <= {n2_rem, r1_lo};
        end
    end

    assign o_days = r2_days;
    assign o_tod  = r2_tod;

endmodule

### hw/rtl/s2cd_date.sv
`timescale 1ns / 1ps

// Stages 3 to 9: Julian day to Gregorian year, month and day.
module s2cd_date (
    input  logic                i_clk,
    input  s2cd_pkg::t_stg_en   i_en,
    input  logic [15:0]         i_days,
    output s2cd_pkg::t_date_out o_date
);

    // Stage 3: shifted day number and century.
    logic [21:0] n3_a;
    logic [23:0] n3_q;
    logic [6:0]  n3_cen;
    logic [21:0] r3_a;
    logic [6:0]  r3_cen;

    // Stage 4: day within the century.
    logic [23:0] n4_cdays;
    logic [15:0] n4_a2;
    logic [15:0] r4_a2;
    logic [6:0]  r4_cen;

    // Stage 5: product for the year within the century.
    logic [36:0] n5_prod;
    logic [36:0] r5_prod;
    logic [15:0] r5_a2;
    logic [6:0]  r5_cen;

    // Stage 6: day within the shifted year.
    logic [6:0]  n6_yic;
    logic [17:0] n6_ydays;
    logic [8:0]  n6_a3;
    logic [8:0]  r6_a3;
    logic [6:0]  r6_yic;
    logic [6:0]  r6_cen;

    // Stage 7: product for the month index.
    logic [22:0] n7_prod;
    logic [22:0] r7_prod;
    logic [8:0]  r7_a3;
    logic [6:0]  r7_yic;
    logic [6:0]  r7_cen;

    // Stage 8: month index, month, year and the month start numerator.
    logic [3:0]  n8_mi;
    logic        n8_wrap;
    logic [10:0] n8_t;
    logic [3:0]  n8_mon;
    logic [12:0] n8_yr;
    logic [10:0] r8_t;
    logic [8:0]  r8_a3;
    logic [3:0]  r8_mon;
    logic [11:0] r8_yr;

    // Stage 9: day of month.
    logic [22:0] n9_prod;
    logic [8:0]  n9_start;
    logic [4:0]  n9_dom;
    s2cd_pkg::t_date_out r9_date;

    always_comb begin
        n3_a   = s2cd_pkg::A_BASE + 22'(i_days);
        n3_q   = {n3_a, 2'b11};
        n3_cen = 7'(s2cd_pkg::CEN_MIN) + 7'(n3_q >= s2cd_pkg::CEN_TH1)
                 + 7'(n3_q >= s2cd_pkg::CEN_TH2);

        n4_cdays = 24'(r3_cen) * 24'(s2cd_pkg::DAYS_400Y);
        n4_a2    = 16'(r3_a - n4_cdays[23:2]);

        n5_prod = 37'({r4_a2, 2'b11}) * 37'(s2cd_pkg::RCP_YIC);

        n6_yic   = r5_prod[s2cd_pkg::YIC_K+6:s2cd_pkg::YIC_K];
        n6_ydays = 18'(n6_yic) * 18'(s2cd_pkg::DAYS_4Y);
        n6_a3    = 9'(r5_a2 - 16'(n6_ydays[17:2]));

        n7_prod = (23'(r6_a3) * 23'(5) + 23'(2)) * 23'(s2cd_pkg::RCP_MI);

        n8_mi   = r7_prod[s2cd_pkg::MI_K+3:s2cd_pkg::MI_K];
        n8_wrap = (n8_mi >= 4'd10);
        n8_t    = 11'(n8_mi) * 11'(s2cd_pkg::MONTH_SPAN) + 11'(2);
        n8_mon  = n8_wrap ? (n8_mi - 4'd9) : (n8_mi + 4'd3);
        n8_yr   = 13'(r7_cen) * 13'(100) + 13'(r7_yic) + 13'(n8_wrap)
                  - 13'(s2cd_pkg::YEAR_BIAS);

        n9_prod  = 23'(r8_t) * 23'(s2cd_pkg::RCP_5);
        n9_start = n9_prod[s2cd_pkg::DIV5_K+8:s2cd_pkg::DIV5_K];
        n9_dom   = 5'(r8_a3 - n9_start + 9'd1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_a   <= n3_a;
            r3_cen <= n3_cen;
        end
        if (i_en[3]) begin
            r4_a2  <= n4_a2;
            r4_cen <= r3_cen;
        end
        if (i_en[4]) begin
            r5_prod <= n5_prod;
            r5_a2   <= r4_a2;
            r5_cen  <= r4_cen;
        end
        if (i_en[5]) begin
            r6_a3  <= n6_a3;
            r6_yic <= n6_yic;
            r6_cen <= r5_cen;
        end
        if (i_en[6]) begin
            r7_prod <= n7_prod;
            r7_a3   <= r6_a3;
            r7_yic  <= r6_yic;
            r7_cen  <= r6_cen;
        end
        if (i_en[7]) begin
            r8_t   <= n8_t;
            r8_a3  <= r7_a3;
            r8_mon <= n8_mon;
            r8_yr  <= n8_yr[11:0];
        end
        if (i_en[8]) begin
            r9_date.year         <= r8_yr;
            r9_date.month        <= r8_mon;
            r9_date.day_of_month <= n9_dom;
        end
    end

    assign o_date = r9_date;

endmodule

### hw/rtl/s2cd_clock.sv
`timescale 1ns / 1ps

// Stages 3 to 9: hour, minute, second and weekday. The results are ready
// after stage 6 and are delayed to line up with the date path.
module s2cd_clock (
    input  logic                 i_clk,
    input  s2cd_pkg::t_stg_en    i_en,
    input  logic [15:0]          i_days,
    input  logic [16:0]          i_tod,
    output s2cd_pkg::t_clock_out o_clock
);

    logic [34:0] n3_hprod;
    logic [16:0] n3_wv;
    logic [34:0] n3_wprod;
    logic [34:0] r3_hprod;
    logic [16:0] r3_tod;
    logic [34:0] r3_wprod;
    logic [16:0] r3_wv;

    logic [4:0]  n4_hour;
    logic [16:0] n4_hsec;
    logic [11:0] n4_rest;
    logic [14:0] n4_weeks;
    logic [16:0] n4_wdays;
    logic [2:0]  n4_wd;
    logic [4:0]  r4_hour;
    logic [11:0] r4_rest;
    logic [2:0]  r4_wd;

    logic [24:0] n5_mprod;
    logic [24:0] r5_mprod;
    logic [11:0] r5_rest;
    logic [4:0]  r5_hour;
    logic [2:0]  r5_wd;

    logic [5:0]  n6_min;
    logic [11:0] n6_msec;
    logic [5:0]  n6_sec;
    s2cd_pkg::t_clock_out r6_clk;
    s2cd_pkg::t_clock_out r7_clk;
    s2cd_pkg::t_clock_out r8_clk;
    s2cd_pkg::t_clock_out r9_clk;

    always_comb begin
        n3_hprod = 35'(i_tod) * 35'(s2cd_pkg::RCP_HOUR);
        n3_wv    = 17'(i_days) + 17'(s2cd_pkg::WD_OFS);
        n3_wprod = 35'(n3_wv) * 35'(s2cd_pkg::RCP_WD);

        n4_hour  = r3_hprod[s2cd_pkg::HOUR_K+4:s2cd_pkg::HOUR_K];
        n4_hsec  = 17'(n4_hour) * 17'(s2cd_pkg::SEC_HOUR);
        n4_rest  = 12'(r3_tod - n4_hsec);
        n4_weeks = r3_wprod[34:s2cd_pkg::WD_K];
        n4_wdays = 17'(n4_weeks) * 17'(s2cd_pkg::WEEK_DAYS);
        n4_wd    = 3'(r3_wv - n4_wdays);

        n5_mprod = 25'(r4_rest) * 25'(s2cd_pkg::RCP_MIN);

        n6_min  = r5_mprod[s2cd_pkg::MIN_K+5:s2cd_pkg::MIN_K];
        n6_msec = 12'(n6_min) * 12'(s2cd_pkg::SEC_MIN);
        n6_sec  = 6'(r5_rest - n6_msec);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_hprod <= n3_hprod;
            r3_tod   <= i_tod;
            r3_wprod <= n3_wprod;
            r3_wv    <= n3_wv;
        end
        if (i_en[3]) begin
            r4_hour <= n4_hour;
            r4_rest <= n4_rest;
            r4_wd   <= n4_wd;
        end
        if (i_en[4]) begin
            r5_mprod <= n5_mprod;
            r5_rest  <= r4_rest;
            r5_hour  <= r4_hour;
            r5_wd    <= r4_wd;
        end
        if (i_en[5]) begin
            r6_clk.hour    <= r5_hour;
            r6_clk.minute  <= n6_min;
            r6_clk.second  <= n6_sec;
            r6_clk.weekday <= r5_wd;
        end
        if (i_en[6]) begin
            r7_clk <= r6_clk;
        end
        if (i_en[7]) begin
            r8_clk <= r7_clk;
        end
        if (i_en[8]) begin
            r9_clk <= r8_clk;
        end
    end

    assign o_clock = r9_clk;

endmodule

### hw/rtl/seconds_to_calendar_date_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Beat content (lowest bit first)
// --------  ---  ----------------------------------------------------------
// s_axis    in   tdata[31:0] seconds_count
// m_axis    out  tdata[47:0] year, month, day_of_month, hour, minute,
//                second, weekday, zero fill
//
// The converter is a nine-stage pipeline that takes one beat in every cycle
// while the output is not stalled and delivers its result from stage nine.
// The latency is set by the chain of reciprocal multiplies in the date path.
// Reset clears only the stage valid bits; the data registers need no reset.
// Each stage holds its beat while the stage after it is full and stalled, so
// bubbles close up and the input keeps accepting until every stage is full.
module seconds_to_calendar_date_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] seconds_count

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [11:0] year, [15:12] month,
                                        // [20:16] day_of_month, [25:21] hour,
                                        // [31:26] minute, [37:32] second,
                                        // [40:38] weekday, [47:41] zero
);

    localparam int unsigned LAST = s2cd_pkg::NUM_STG - 1;

    // One valid bit per stage; a stage may load whenever it is empty or its
    // current beat moves on in the same cycle.
    logic [s2cd_pkg::NUM_STG-1:0] r_vld;
    logic [s2cd_pkg::NUM_STG-1:0] n_vld;
    s2cd_pkg::t_stg_en            stg_en;

    logic [15:0]          days;
    logic [16:0]          tod;
    s2cd_pkg::t_date_out  date;
    s2cd_pkg::t_clock_out clock;

    always_comb begin
        stg_en[LAST] = !r_vld[LAST] || m_axis_tready;
        for (int k = LAST - 1; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (stg_en[0]) begin
            n_vld[0] = s_axis_tvalid;
        end
        for (int k = 1; k < s2cd_pkg::NUM_STG; k++) begin
            if (stg_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Whole days and seconds within the day.
    s2cd_day_split u_day_split (
        .i_clk           (i_clk),
        .i_en            (stg_en),
        .i_seconds_count (s_axis_tdata),
        .o_days          (days),
        .o_tod           (tod)
    );

    // Gregorian date from the day count.
    s2cd_date u_date (
        .i_clk  (i_clk),
        .i_en   (stg_en),
        .i_days (days),
        .o_date (date)
    );

    // Time of day and weekday, aligned with the date path.
    s2cd_clock u_clock (
        .i_clk   (i_clk),
        .i_en    (stg_en),
        .i_days  (days),
        .i_tod   (tod),
        .o_clock (clock)
    );

    assign s_axis_tready = stg_en[0];
    assign m_axis_tvalid = r_vld[LAST];
    assign m_axis_tdata  = {7'd0, clock.weekday, clock.second, clock.minute, clock.hour,
                            date.day_of_month, date.month, date.year};

endmodule
